[sv/pnps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnps_pkg: Poisson noise pixel scaler package
// Widths, reset values, microcode types and the control store.
// ----------------------------------------------------------------------------
package pnps_pkg;

    localparam int MAX_COUNT_DEF = 1000;

    localparam int LAM_W  = 24;   // lambda, Q8.16
    localparam int EXP_W  = 33;   // e^-lambda, Q0.32 (may reach 2^32)
    localparam int U_W    = 32;
    localparam int PIX_W  = 32;
    localparam int CNT_W  = 10;   // poisson_count field
    localparam int TERM_W = 34;   // term clamps to 2^33
    localparam int SUM_W  = 34;
    localparam int ACC_W  = 58;   // term * lambda
    localparam int QUO_W  = ACC_W - 16;
    localparam int DIVC_W = $clog2(QUO_W + 1);
    localparam int CFG_IDX_W = 4;
    localparam int MA_W   = 33;   // shared multiplier operand widths
    localparam int MB_W   = 25;
    localparam int HALF_W = 17;   // term split for the two partial products

    localparam logic [LAM_W-1:0]  LAM_RESET  = 24'd65536;
    localparam logic [EXP_W-1:0]  EXP_RESET  = 33'd1580030169;
    localparam logic [TERM_W-1:0] TERM_CLAMP = 34'h2_0000_0000;
    localparam logic [CNT_W-1:0]  CNT_FIELD_MAX = 10'd1023;

    localparam logic [CFG_IDX_W-1:0] REG_LAMBDA = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXP    = 4'd1;

    typedef enum logic [3:0] {
        S_IDLE    = 4'd0,
        S_CHK0    = 4'd1,
        S_MUL_LO  = 4'd2,
        S_MUL_HI  = 4'd3,
        S_DIV_LD  = 4'd4,
        S_DIV_RUN = 4'd5,
        S_UPDATE  = 4'd6,
        S_TEST    = 4'd7,
        S_LOOP    = 4'd8,
        S_CAP     = 4'd9,
        S_SCL_RE  = 4'd10,
        S_SCL_IM  = 4'd11,
        S_EMIT    = 4'd12
    } step_t;

    typedef enum logic [1:0] {
        MUL_TLO = 2'd0,
        MUL_THI = 2'd1,
        MUL_RE  = 2'd2,
        MUL_IM  = 2'd3
    } mul_sel_t;

    typedef enum logic [1:0] {
        K_HOLD = 2'd0,
        K_CLR  = 2'd1,
        K_INC  = 2'd2,
        K_MAX  = 2'd3
    } k_ctl_t;

    typedef enum logic [2:0] {
        C_NONE       = 3'd0,
        C_IN_XFER    = 3'd1,
        C_SUM_GE     = 3'd2,
        C_DIV_DONE   = 3'd3,
        C_Q_ZERO     = 3'd4,
        C_K_NOT_LAST = 3'd5,
        C_OUT_FREE   = 3'd6
    } cond_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        logic     acc_en;
        logic     acc_add;
        logic     div_load;
        logic     div_step;
        logic     term_en;
        logic     re_en;
        logic     im_en;
        logic     out_load;
        logic     in_take;
        k_ctl_t   k_ctl;
        cond_t    cond;
        logic     wait_else;   // cond false: stay instead of falling through
        step_t    target;
    } ctrl_t;

    // Control store: next = cond ? target : (wait_else ? pc : pc + 1)
    function automatic ctrl_t ucode(step_t pc);
        ctrl_t cw;
        cw = '0;
        cw.mul_sel = MUL_TLO;
        cw.k_ctl   = K_HOLD;
        cw.cond    = C_NONE;
        cw.target  = S_IDLE;
        case (pc)
            S_IDLE:
            begin
                cw.in_take   = 1'b1;
                cw.k_ctl     = K_CLR;
                cw.cond      = C_IN_XFER;
                cw.wait_else = 1'b1;
                cw.target    = S_CHK0;
            end
            S_CHK0:
            begin
                cw.cond   = C_SUM_GE;
                cw.target = S_SCL_RE;
            end
            S_MUL_LO:
            begin
                cw.mul_sel = MUL_TLO;
                cw.acc_en  = 1'b1;
                cw.k_ctl   = K_INC;
            end
            S_MUL_HI:
            begin
                cw.mul_sel = MUL_THI;
                cw.acc_en  = 1'b1;
                cw.acc_add = 1'b1;
            end
            S_DIV_LD:
            begin
                cw.div_load = 1'b1;
            end
            S_DIV_RUN:
            begin
                cw.div_step  = 1'b1;
                cw.cond      = C_DIV_DONE;
                cw.wait_else = 1'b1;
                cw.target    = S_UPDATE;
            end
            S_UPDATE:
            begin
                cw.term_en = 1'b1;
                cw.cond    = C_Q_ZERO;
                cw.target  = S_CAP;
            end
            S_TEST:
            begin
                cw.cond   = C_SUM_GE;
                cw.target = S_SCL_RE;
            end
            S_LOOP:
            begin
                cw.cond   = C_K_NOT_LAST;
                cw.target = S_MUL_LO;
            end
            S_CAP:
            begin
                cw.k_ctl = K_MAX;
            end
            S_SCL_RE:
            begin
                cw.mul_sel = MUL_RE;
                cw.re_en   = 1'b1;
            end
            S_SCL_IM:
            begin
                cw.mul_sel = MUL_IM;
                cw.im_en   = 1'b1;
            end
            S_EMIT:
            begin
                cw.out_load  = 1'b1;
                cw.cond      = C_OUT_FREE;
                cw.wait_else = 1'b1;
                cw.target    = S_IDLE;
            end
            default:
            begin
                cw.target = S_IDLE;
                cw.cond   = C_NONE;
            end
        endcase
        return cw;
    endfunction

endpackage

[sv/poisson_noise_pixel_scaler_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poisson_noise_pixel_scaler_top: Poisson count draw and complex pixel scaling
// Microcoded sequencer: inverse-transform Poisson draw, then saturating
// multiply of both pixel parts by the count.
// ----------------------------------------------------------------------------
// One pixel at a time. A term that truncates to zero at step j gives the count
// MAX_COUNT, and so does running every step up to MAX_COUNT-1 without
// covering the draw. Each term update is two partial products on the
// shared 33x25 multiplier plus a 42-step shift-subtract divide by k, and the
// divider sets the loop length. The next pixel is taken as soon as the result
// sits in the output register, so a stalled output only blocks once the
// following result is ready. Registers are to be written through cfg_* only
// while idle; the block itself does not enforce this, and cfg_ready is always
// high.
module poisson_noise_pixel_scaler_top #(
    parameter int MAX_COUNT = pnps_pkg::MAX_COUNT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pnps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pnps_pkg::EXP_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [pnps_pkg::U_W-1:0]            uniform_draw,
    input  logic signed [pnps_pkg::PIX_W-1:0]   real_in,
    input  logic signed [pnps_pkg::PIX_W-1:0]   imag_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [pnps_pkg::PIX_W-1:0]   real_out,
    output logic signed [pnps_pkg::PIX_W-1:0]   imag_out,
    output logic [pnps_pkg::CNT_W-1:0]          poisson_count,
    output logic                                clipped
);

    localparam int KW = $clog2(MAX_COUNT + 1);
    localparam int XW = (KW > pnps_pkg::CNT_W) ? KW : pnps_pkg::CNT_W;
    localparam logic [KW-1:0] K_LAST = KW'(MAX_COUNT - 1);
    localparam logic [KW-1:0] K_CAP  = KW'(MAX_COUNT);

    localparam logic signed [pnps_pkg::MA_W+pnps_pkg::MB_W-1:0] SAT_HI =
        (pnps_pkg::MA_W + pnps_pkg::MB_W)'(64'sd2147483647);
    localparam logic signed [pnps_pkg::MA_W+pnps_pkg::MB_W-1:0] SAT_LO =
        (pnps_pkg::MA_W + pnps_pkg::MB_W)'(-64'sd2147483648);

    // configuration
    logic [pnps_pkg::LAM_W-1:0] lam_reg;
    logic [pnps_pkg::EXP_W-1:0] exp_reg;

    // sequencer
    pnps_pkg::step_t pc_reg, pc_next;
    pnps_pkg::ctrl_t cw;
    logic            cond_hit;

    // datapath
    logic [pnps_pkg::U_W-1:0]          u_reg;
    logic signed [pnps_pkg::PIX_W-1:0] re_reg, im_reg;
    logic [pnps_pkg::TERM_W-1:0]       term_reg;
    logic [pnps_pkg::SUM_W-1:0]        sum_reg;
    logic [pnps_pkg::SUM_W-1:0]        sum_new;
    logic [KW-1:0]                     k_reg, k_next;
    logic [pnps_pkg::ACC_W-1:0]        acc_reg;

    logic signed [pnps_pkg::MA_W-1:0]                 mul_a;
    logic signed [pnps_pkg::MB_W-1:0]                 mul_b;
    logic signed [pnps_pkg::MA_W+pnps_pkg::MB_W-1:0]  prod;
    logic                                             sat;
    logic signed [pnps_pkg::PIX_W-1:0]                sat_val;

    // divider
    logic [pnps_pkg::QUO_W-1:0]  quo_reg;
    logic [KW-1:0]               rem_reg;
    logic [pnps_pkg::DIVC_W-1:0] divc_reg;
    logic [KW:0]                 trial, diff;
    logic                        trial_ge;
    logic [pnps_pkg::TERM_W-1:0] q_clamp;

    // result staging and output register
    logic signed [pnps_pkg::PIX_W-1:0] res_re_reg, res_im_reg;
    logic                              clip_reg;
    logic                              out_valid_reg;
    logic signed [pnps_pkg::PIX_W-1:0] real_out_reg, imag_out_reg;
    logic [pnps_pkg::CNT_W-1:0]        count_out_reg;
    logic                              clipped_out_reg;
    logic [XW-1:0]                     k_ext;
    logic [pnps_pkg::CNT_W-1:0]        count_field;

    logic in_xfer, out_free, out_ld;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lam_reg <= pnps_pkg::LAM_RESET;
            exp_reg <= pnps_pkg::EXP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == pnps_pkg::REG_LAMBDA)
            begin
                lam_reg <= cfg_data[pnps_pkg::LAM_W-1:0];
            end
            else if (cfg_index == pnps_pkg::REG_EXP)
            begin
                exp_reg <= cfg_data;
            end
        end
    end

    // ---------------- sequencer ----------------
    assign cw       = pnps_pkg::ucode(pc_reg);
    assign in_xfer  = in_valid && cw.in_take;
    assign in_stall = !cw.in_take;
    assign out_free = !out_valid_reg || !out_stall;
    assign out_ld   = cw.out_load && out_free;

    always_comb
    begin
        case (cw.cond)
            pnps_pkg::C_IN_XFER:    cond_hit = in_xfer;
            pnps_pkg::C_SUM_GE:     cond_hit = (sum_reg >= pnps_pkg::SUM_W'(u_reg));
            pnps_pkg::C_DIV_DONE:   cond_hit = (divc_reg == pnps_pkg::DIVC_W'(1));
            pnps_pkg::C_Q_ZERO:     cond_hit = (q_clamp == '0);
            pnps_pkg::C_K_NOT_LAST: cond_hit = (k_reg != K_LAST);
            pnps_pkg::C_OUT_FREE:   cond_hit = out_free;
            default:                cond_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        if (cond_hit)
        begin
            pc_next = cw.target;
        end
        else if (cw.wait_else)
        begin
            pc_next = pc_reg;
        end
        else
        begin
            pc_next = pnps_pkg::step_t'(pc_reg + 4'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= pnps_pkg::S_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    // ---------------- shared multiplier ----------------
    always_comb
    begin
        case (cw.mul_sel)
            pnps_pkg::MUL_TLO:
            begin
                mul_a = signed'({16'b0, term_reg[pnps_pkg::HALF_W-1:0]});
                mul_b = signed'({1'b0, lam_reg});
            end
            pnps_pkg::MUL_THI:
            begin
                mul_a = signed'({16'b0, term_reg[pnps_pkg::TERM_W-1:pnps_pkg::HALF_W]});
                mul_b = signed'({1'b0, lam_reg});
            end
            pnps_pkg::MUL_RE:
            begin
                mul_a = signed'({re_reg[pnps_pkg::PIX_W-1], re_reg});
                mul_b = signed'(pnps_pkg::MB_W'(k_reg));
            end
            default:
            begin
                mul_a = signed'({im_reg[pnps_pkg::PIX_W-1], im_reg});
                mul_b = signed'(pnps_pkg::MB_W'(k_reg));
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    always_comb
    begin
        sat     = 1'b0;
        sat_val = prod[pnps_pkg::PIX_W-1:0];
        if (prod > SAT_HI)
        begin
            sat     = 1'b1;
            sat_val = 32'sh7FFF_FFFF;
        end
        else if (prod < SAT_LO)
        begin
            sat     = 1'b1;
            sat_val = 32'sh8000_0000;
        end
    end

    // ---------------- divider: quotient of acc/65536 by k ----------------
    assign trial    = {rem_reg, quo_reg[pnps_pkg::QUO_W-1]};
    assign trial_ge = (trial >= {1'b0, k_reg});
    assign diff     = trial - {1'b0, k_reg};
    assign q_clamp  = (quo_reg > pnps_pkg::QUO_W'(pnps_pkg::TERM_CLAMP)) ?
                      pnps_pkg::TERM_CLAMP : quo_reg[pnps_pkg::TERM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divc_reg <= '0;
        end
        else if (cw.div_load)
        begin
            divc_reg <= pnps_pkg::DIVC_W'(pnps_pkg::QUO_W);
        end
        else if (cw.div_step && (divc_reg != '0))
        begin
            divc_reg <= divc_reg - pnps_pkg::DIVC_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cw.div_load)
        begin
            quo_reg <= acc_reg[pnps_pkg::ACC_W-1:16];
            rem_reg <= '0;
        end
        else if (cw.div_step && (divc_reg != '0))
        begin
            quo_reg <= {quo_reg[pnps_pkg::QUO_W-2:0], trial_ge};
            rem_reg <= trial_ge ? diff[KW-1:0] : trial[KW-1:0];
        end
    end

    // ---------------- term, sum, count ----------------
    // sum < uniform < 2^32 before each add and term <= 2^33, so 34 bits hold it
    assign sum_new = sum_reg + q_clamp;

    always_comb
    begin
        case (cw.k_ctl)
            pnps_pkg::K_CLR: k_next = '0;
            pnps_pkg::K_INC: k_next = k_reg + KW'(1);
            pnps_pkg::K_MAX: k_next = K_CAP;
            default:         k_next = k_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= '0;
        end
        else
        begin
            k_reg <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            u_reg    <= uniform_draw;
            re_reg   <= real_in;
            im_reg   <= imag_in;
            term_reg <= pnps_pkg::TERM_W'(exp_reg);
            sum_reg  <= pnps_pkg::SUM_W'(exp_reg);
        end
        else if (cw.term_en)
        begin
            term_reg <= q_clamp;
            sum_reg  <= sum_new;
        end
        if (cw.acc_en)
        begin
            if (cw.acc_add)
            begin
                acc_reg <= acc_reg + {prod[pnps_pkg::ACC_W-pnps_pkg::HALF_W-1:0],
                                      pnps_pkg::HALF_W'(0)};
            end
            else
            begin
                acc_reg <= unsigned'(prod);
            end
        end
        if (cw.re_en)
        begin
            res_re_reg <= sat_val;
            clip_reg   <= sat;
        end
        if (cw.im_en)
        begin
            res_im_reg <= sat_val;
            clip_reg   <= clip_reg | sat;
        end
    end

    // ---------------- output register ----------------
    assign k_ext       = XW'(k_reg);
    assign count_field = (k_ext > XW'(pnps_pkg::CNT_FIELD_MAX)) ?
                         pnps_pkg::CNT_FIELD_MAX : k_ext[pnps_pkg::CNT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ld)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ld)
        begin
            real_out_reg    <= res_re_reg;
            imag_out_reg    <= res_im_reg;
            count_out_reg   <= count_field;
            clipped_out_reg <= clip_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign real_out      = real_out_reg;
    assign imag_out      = imag_out_reg;
    assign poisson_count = count_out_reg;
    assign clipped       = clipped_out_reg;

`ifndef SYNTHESIS
    a_accept_starts_draw: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (pc_reg == pnps_pkg::S_CHK0))
        else $error("accepted pixel did not start a draw");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == pnps_pkg::S_DIV_LD) |-> (k_reg != '0))
        else $error("divider loaded with zero divisor");

    a_count_capped: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg <= K_CAP)
        else $error("count beyond iteration cap");

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        ((pc_reg == pnps_pkg::S_EMIT) && out_free) |=> (out_valid && (pc_reg == pnps_pkg::S_IDLE)))
        else $error("result not moved to output register");
`endif

endmodule

[tb/tb_poisson_noise_pixel_scaler_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_poisson_noise_pixel_scaler_top: self-checking bench for the pixel scaler
// Drives complex pixels with uniform draws through the valid/stall input,
// predicts the Poisson count and the saturated products of every transfer,
// and checks each output transfer against the oldest prediction. Covers
// reset settings, register extremes, ignored register indexes, matched
// lambda / e^-lambda settings and arbitrary register pairs, with bursty
// input traffic and patterned output stalls.
// ----------------------------------------------------------------------------
module tb_poisson_noise_pixel_scaler_top;

    localparam int unsigned MAX_COUNT    = pnps_pkg::MAX_COUNT_DEF;
    localparam int          LIMIT_CYCLES = 4_000_000;
    localparam int          DRAIN_CYCLES = 64;
    localparam longint      SAT_HI       = 64'sd2147483647;
    localparam longint      SAT_LO       = -64'sd2147483648;
    // decodes to nothing
    localparam logic [pnps_pkg::CFG_IDX_W-1:0] REG_SPARE = 4'hF;
    localparam logic [pnps_pkg::LAM_W-1:0]     LAM_MAX   = '1;
    localparam logic [pnps_pkg::EXP_W-1:0]     EXP_ONE   = 33'h1_0000_0000;

    typedef enum int {
        STALL_NONE  = 0,
        STALL_COIN  = 1,
        STALL_HEAVY = 2
    } stall_mode_t;

    typedef struct packed {
        logic signed [pnps_pkg::PIX_W-1:0] real_part;
        logic signed [pnps_pkg::PIX_W-1:0] imag_part;
        logic [pnps_pkg::CNT_W-1:0]        count;
        logic                              clip;
    } pixel_result_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [pnps_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [pnps_pkg::EXP_W-1:0]          cfg_data = '0;
    logic                                in_valid = 1'b0;
    logic                                in_stall;
    logic [pnps_pkg::U_W-1:0]            uniform_draw = '0;
    logic signed [pnps_pkg::PIX_W-1:0]   real_in = '0;
    logic signed [pnps_pkg::PIX_W-1:0]   imag_in = '0;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic signed [pnps_pkg::PIX_W-1:0]   real_out;
    logic signed [pnps_pkg::PIX_W-1:0]   imag_out;
    logic [pnps_pkg::CNT_W-1:0]          poisson_count;
    logic                                clipped;

    // register mirror
    bit [pnps_pkg::LAM_W-1:0]   lam_cfg = pnps_pkg::LAM_RESET;
    bit [pnps_pkg::EXP_W-1:0]   exp_cfg = pnps_pkg::EXP_RESET;

    pixel_result_t    pending_pixels[$];
    pixel_result_t    want;
    int unsigned      mismatches = 0;
    int unsigned      cycle_count = 0;
    int unsigned      burst_left = 0;
    stall_mode_t      stall_mode = STALL_NONE;
    int unsigned      mode_left = 0;

    poisson_noise_pixel_scaler_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .uniform_draw  (uniform_draw),
        .real_in       (real_in),
        .imag_in       (imag_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .real_out      (real_out),
        .imag_out      (imag_out),
        .poisson_count (poisson_count),
        .clipped       (clipped)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // inverse transform: accumulate terms until the sum covers the draw
    function automatic int unsigned draw_poisson_count(bit [pnps_pkg::U_W-1:0] u);
        bit [63:0] term;
        bit [63:0] total;
        term  = 64'(exp_cfg);
        total = term;
        if (total >= 64'(u))
            return 0;
        for (int unsigned k = 1; k < MAX_COUNT; k++)
        begin
            term = (term * 64'(lam_cfg)) / (64'(k) << 16);
            if (term > 64'(pnps_pkg::TERM_CLAMP))
                term = 64'(pnps_pkg::TERM_CLAMP);
            if (term == 0)
                return MAX_COUNT;   // sum is stuck below the draw
            total += term;
            if (total >= 64'(u))
                return k;
        end
        return MAX_COUNT;
    endfunction

    function automatic bit signed [pnps_pkg::PIX_W-1:0] saturate32(longint p);
        if (p > SAT_HI)
            return SAT_HI[pnps_pkg::PIX_W-1:0];
        if (p < SAT_LO)
            return SAT_LO[pnps_pkg::PIX_W-1:0];
        return p[pnps_pkg::PIX_W-1:0];
    endfunction

    function automatic pixel_result_t predict_pixel(
        bit [pnps_pkg::U_W-1:0] u,
        bit signed [pnps_pkg::PIX_W-1:0] re,
        bit signed [pnps_pkg::PIX_W-1:0] im);
        int unsigned   cnt;
        longint        prod_re;
        longint        prod_im;
        pixel_result_t r;
        cnt         = draw_poisson_count(u);
        prod_re     = longint'(re) * longint'(cnt);
        prod_im     = longint'(im) * longint'(cnt);
        r.real_part = saturate32(prod_re);
        r.imag_part = saturate32(prod_im);
        r.clip      = (longint'(r.real_part) != prod_re) ||
                      (longint'(r.imag_part) != prod_im);
        r.count     = (cnt > 32'(pnps_pkg::CNT_FIELD_MAX)) ?
                      pnps_pkg::CNT_FIELD_MAX : cnt[pnps_pkg::CNT_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic check_field(string name, logic [pnps_pkg::PIX_W-1:0] want_v,
                               logic [pnps_pkg::PIX_W-1:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch, expected %h, got %h",
                     $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: unexpected transfer, got re=%h im=%h count=%0d clip=%b",
                         $time, real_out, imag_out, poisson_count, clipped);
                mismatches++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                check_field("real_out", want.real_part, real_out);
                check_field("imag_out", want.imag_part, imag_out);
                check_field("poisson_count", 32'(want.count), 32'(poisson_count));
                check_field("clipped", 32'(want.clip), 32'(clipped));
            end
        end
    end

    // output back-pressure: switches between free, coin-flip and heavy stalling
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 2));
            mode_left  = $urandom_range(16, 256);
        end
        else
            mode_left--;
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_COIN:  out_stall <= 1'($urandom_range(0, 1));
            default:     out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    task automatic write_reg(logic [pnps_pkg::CFG_IDX_W-1:0] idx,
                             logic [pnps_pkg::EXP_W-1:0] data, bit more);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (!more)
            cfg_valid <= 1'b0;
        case (idx)
            pnps_pkg::REG_LAMBDA: lam_cfg = data[pnps_pkg::LAM_W-1:0];
            pnps_pkg::REG_EXP:    exp_cfg = data;
            default:              ;
        endcase
    endtask

    task automatic set_config(logic [pnps_pkg::LAM_W-1:0] lam,
                              logic [pnps_pkg::EXP_W-1:0] p0);
        write_reg(pnps_pkg::REG_LAMBDA, pnps_pkg::EXP_W'(lam), 1'b1);
        write_reg(pnps_pkg::REG_EXP, p0, 1'b0);
    endtask

    // input side runs in bursts with random gaps in between
    task automatic send_pixel(bit [pnps_pkg::U_W-1:0] u,
                              bit signed [pnps_pkg::PIX_W-1:0] re,
                              bit signed [pnps_pkg::PIX_W-1:0] im);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid     <= 1'b1;
        uniform_draw <= u;
        real_in      <= re;
        imag_in      <= im;
        do
            @(posedge clk);
        while (in_stall);
        pending_pixels.push_back(predict_pixel(u, re, im));
        burst_left--;
    endtask

    // stop sending and let every outstanding result come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_pixels.size() != 0);
    endtask

    function automatic bit signed [pnps_pkg::PIX_W-1:0] rand_pixel();
        bit signed [pnps_pkg::PIX_W-1:0] v;
        v = $urandom;
        case ($urandom_range(0, 3))
            0: v = v >>> $urandom_range(8, 31);
            1: v = v >>> $urandom_range(20, 31);
            default: ;
        endcase
        return v;
    endfunction

    function automatic bit [pnps_pkg::U_W-1:0] rand_uniform();
        if ($urandom_range(0, 7) == 0)
            return 32'hFFFF_FFFF - $urandom_range(0, 1 << 20);   // tail of the draw
        return $urandom;
    endfunction

    task automatic send_random(int unsigned n);
        repeat (n) send_pixel(rand_uniform(), rand_pixel(), rand_pixel());
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // reset settings: lambda 1.0, e^-1; counts 0, 1, 2 and the cap
    task automatic test_reset_defaults();
        send_pixel(32'd0, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_pixel(pnps_pkg::EXP_RESET[pnps_pkg::U_W-1:0], -32'sd1, 32'sd1);
        send_pixel(pnps_pkg::EXP_RESET[pnps_pkg::U_W-1:0] + 32'd1,
                   32'sh8000_0000, 32'sh7FFF_FFFF);
        send_pixel(32'd2 * pnps_pkg::EXP_RESET[pnps_pkg::U_W-1:0] + 32'd1,
                   32'sh8000_0000, 32'sh7FFF_FFFF);
        send_pixel(32'hFFFF_FFFF, 32'sd1, -32'sd1);
        send_pixel(32'hFFFF_FFFF, 32'sd2147483, -32'sd2147484);
        send_pixel(32'd0, 32'sd0, 32'sd0);
        send_pixel(32'h8000_0000, 32'sh5555_5555, 32'shAAAA_AAAA);
    endtask

    task automatic send_corner_draws();
        send_pixel(32'd0, rand_pixel(), rand_pixel());
        send_pixel(32'd1, rand_pixel(), rand_pixel());
        send_pixel(32'hFFFF_FFFF, rand_pixel(), rand_pixel());
    endtask

    task automatic test_register_extremes();
        wait_idle();
        set_config('0, pnps_pkg::EXP_RESET);      // first update already zero
        send_corner_draws();
        wait_idle();
        set_config(LAM_MAX, '0);
        send_corner_draws();
        wait_idle();
        set_config(LAM_MAX, EXP_ONE);   // first term covers every draw
        send_corner_draws();
        wait_idle();
        set_config('0, EXP_ONE);
        send_corner_draws();
    endtask

    task automatic test_ignored_index();
        wait_idle();
        write_reg(pnps_pkg::REG_LAMBDA, pnps_pkg::EXP_W'(pnps_pkg::LAM_RESET), 1'b1);
        write_reg(pnps_pkg::REG_EXP, pnps_pkg::EXP_RESET, 1'b1);
        write_reg(REG_SPARE, {1'($urandom_range(0, 1)), $urandom}, 1'b0);
        send_random(3);
    endtask

    // e^-lambda consistent with lambda, lambda up to 8.0
    task automatic test_matched_lambda(int unsigned phases, int unsigned items);
        bit [pnps_pkg::LAM_W-1:0] lam;
        bit [63:0]                p0;
        real                      mean;
        for (int unsigned ph = 0; ph < phases; ph++)
        begin
            case (ph)
                0:       lam = 24'd6554;       // 0.1
                1:       lam = 24'h08_0000;    // 8.0
                default: lam = pnps_pkg::LAM_W'($urandom_range(0, 24'h08_0000));
            endcase
            mean = lam / 65536.0;
            p0   = $exp(-mean) * 4294967296.0;
            wait_idle();
            set_config(lam, p0[pnps_pkg::EXP_W-1:0]);
            for (int unsigned i = 0; i < items; i++)
            begin
                if (ph == 2 && i == items / 2)
                    wait_idle();
                send_pixel(rand_uniform(), rand_pixel(), rand_pixel());
            end
        end
    endtask

    // arbitrary register pairs, including e^-lambda out of step with lambda
    task automatic test_mismatched_exp(int unsigned items);
        wait_idle();
        set_config(pnps_pkg::LAM_W'($urandom),
                   {1'($urandom_range(0, 1)), $urandom} % (EXP_ONE + 1));
        send_random(items);
        wait_idle();
        set_config(pnps_pkg::LAM_W'($urandom_range(0, 24'h04_0000)),
                   {1'($urandom_range(0, 1)), $urandom} % (EXP_ONE + 1));
        send_random(items);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_register_extremes();
        test_ignored_index();
        test_matched_lambda(6, 110);
        test_mismatched_exp(70);
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
